>>> rtl/pgtw_pkg.sv
// Shared constants, types and helper functions for the probe grid trilinear weight block.
// Used by pgtw_axis, probe_grid_trilinear_weights and pgtw_checker.
package pgtw_pkg;

    localparam int COUNT_BITS    = 10;
    localparam int WEIGHT_BITS   = 16;
    localparam int GRID_FRAC     = 16;
    localparam int POS_BITS      = 32;
    localparam int INV_BITS      = 24;
    localparam int INDEX_BITS    = 30;
    localparam int CORNER_BITS   = 3;
    localparam int CFG_IDX_BITS  = 3;

    localparam int WGT_W         = WEIGHT_BITS + 1;
    localparam int PROD_W        = 2 * WGT_W;
    localparam int GRID_BITS     = 3 * COUNT_BITS;
    localparam int CFG_DATA_BITS = (GRID_BITS > POS_BITS) ? GRID_BITS : POS_BITS;
    localparam int GCOORD_W      = POS_BITS + INV_BITS;
    localparam int FLOOR_W       = GCOORD_W - GRID_FRAC;
    localparam int IDX_W         = (GRID_BITS > INDEX_BITS) ? GRID_BITS + 2 : INDEX_BITS + 2;
    localparam int FRAC_SHL      = (WEIGHT_BITS >= GRID_FRAC) ? WEIGHT_BITS - GRID_FRAC : 0;
    localparam int FRAC_SHR      = (WEIGHT_BITS >= GRID_FRAC) ? 0 : GRID_FRAC - WEIGHT_BITS;

    typedef logic [COUNT_BITS-1:0]   t_count;
    typedef logic [WGT_W-1:0]        t_weight;
    typedef logic [CORNER_BITS-1:0]  t_corner;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_index;

    localparam t_weight           W_ONE  = t_weight'(1) << WEIGHT_BITS;
    localparam logic [PROD_W-1:0] W_HALF = PROD_W'(1) << (WEIGHT_BITS - 1);

    localparam t_corner LAST_CORNER  = t_corner'(7);
    localparam t_corner FIRST_CORNER = t_corner'(0);

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_DATA = 1'b1;

    localparam t_cfg_index REG_PROBE_VALID = t_cfg_index'(0);
    localparam t_cfg_index REG_ORIGIN_X    = t_cfg_index'(1);
    localparam t_cfg_index REG_ORIGIN_Y    = t_cfg_index'(2);
    localparam t_cfg_index REG_ORIGIN_Z    = t_cfg_index'(3);
    localparam t_cfg_index REG_INV_X       = t_cfg_index'(4);
    localparam t_cfg_index REG_INV_Y       = t_cfg_index'(5);
    localparam t_cfg_index REG_INV_Z       = t_cfg_index'(6);
    localparam t_cfg_index REG_GRID_COUNTS = t_cfg_index'(7);

    localparam logic [INV_BITS-1:0]  INV_RESET    = INV_BITS'(256);
    localparam logic [GRID_BITS-1:0] COUNTS_RESET = GRID_BITS'(1049601);

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_front_en;

    // Rounds a product of two weights back to weight scale, half up.
    function automatic t_weight round_w(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        s = p + W_HALF;
        return s[WEIGHT_BITS +: WGT_W];
    endfunction

endpackage

>>> rtl/probe_grid_trilinear_weights.sv
// Top level of the probe grid trilinear weight block: configuration registers,
// front pipeline of three pgtw_axis units, corner sequencer and back pipeline.
// Depends on pgtw_pkg and pgtw_axis.
//
// A query word (pos_x, pos_y, pos_z) enters on the input channel when i_in_valid is
// high and o_in_stall is low. Each query yields eight result words, corners 0 to 7
// with o_last on corner 7, or one failure word when no probe data is loaded.
// Configuration words are taken on the cfg channel, which is always ready. The user
// sees that they are written only while no query is in flight; the block does not
// enforce this. An accepted query passes through three front stages (offset, scale
// multiply, clamp and weights), then the corner stage and two back stages (weight and
// index products, final rounding) on the way to its first result word.
// The corner sequencer emits one corner per cycle while the output is not stalled;
// a failing query yields a single failure word. Up to two further queries wait in
// the front stages while one is expanded.
// Reset clears all valid bits and the corner counter and loads the register reset
// values. When the receiver stalls, the output word holds and stages fill up
// behind it without losing or repeating a word; o_in_stall rises once the front
// stages are full.
module probe_grid_trilinear_weights (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic signed [pgtw_pkg::POS_BITS-1:0]     i_pos_x,
    input  logic signed [pgtw_pkg::POS_BITS-1:0]     i_pos_y,
    input  logic signed [pgtw_pkg::POS_BITS-1:0]     i_pos_z,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic                                     o_lookup_status,
    output logic [pgtw_pkg::CORNER_BITS-1:0]         o_corner,
    output logic [pgtw_pkg::INDEX_BITS-1:0]          o_probe_index,
    output logic [pgtw_pkg::WGT_W-1:0]               o_corner_weight,
    output logic                                     o_last,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [pgtw_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [pgtw_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);
    import pgtw_pkg::*;

    logic                       r_probe_valid;
    logic signed [POS_BITS-1:0] r_origin_x;
    logic signed [POS_BITS-1:0] r_origin_y;
    logic signed [POS_BITS-1:0] r_origin_z;
    logic [INV_BITS-1:0]        r_inv_x;
    logic [INV_BITS-1:0]        r_inv_y;
    logic [INV_BITS-1:0]        r_inv_z;
    logic [GRID_BITS-1:0]       r_counts;

    t_count                     cx;
    t_count                     cy;
    t_count                     cz;

    t_front_en                  en;
    logic                       en4;
    logic                       en5;
    logic                       en6;
    logic                       emit;
    logic                       q_last;

    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    t_corner                    r_k;
    logic [2*COUNT_BITS-1:0]    r_cxy;

    t_count                     x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
    t_weight                    wx_lo, wx_hi, wy_lo, wy_hi, wz_lo, wz_hi;

    t_count                     sel_ix, sel_iy, sel_iz;
    t_weight                    sel_wx, sel_wy, sel_wz;
    logic [PROD_W-1:0]          n_pxy;
    logic [GRID_BITS-1:0]       n_izxy;
    logic [2*COUNT_BITS-1:0]    n_iyx;

    logic                       r_v4;
    logic                       r_st4;
    t_corner                    r_k4;
    logic                       r_last4;
    logic [PROD_W-1:0]          r_pxy;
    t_weight                    r_wz4;
    logic [GRID_BITS-1:0]       r_izxy;
    logic [2*COUNT_BITS-1:0]    r_iyx;
    t_count                     r_ix4;

    t_weight                    w1;
    logic [PROD_W-1:0]          n_p2;
    logic [IDX_W-1:0]           n_idx;

    logic                       r_v5;
    logic                       r_st5;
    t_corner                    r_k5;
    logic                       r_last5;
    logic [PROD_W-1:0]          r_p2;
    logic [INDEX_BITS-1:0]      r_idx5;

    logic                       r_out_valid;
    logic                       r_status;
    t_corner                    r_corner;
    logic [INDEX_BITS-1:0]      r_index;
    t_weight                    r_weight;
    logic                       r_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_valid <= 1'b0;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_origin_z    <= '0;
            r_inv_x       <= INV_RESET;
            r_inv_y       <= INV_RESET;
            r_inv_z       <= INV_RESET;
            r_counts      <= COUNTS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_PROBE_VALID: r_probe_valid <= i_cfg_data[0];
                REG_ORIGIN_X:    r_origin_x    <= i_cfg_data[POS_BITS-1:0];
                REG_ORIGIN_Y:    r_origin_y    <= i_cfg_data[POS_BITS-1:0];
                REG_ORIGIN_Z:    r_origin_z    <= i_cfg_data[POS_BITS-1:0];
                REG_INV_X:       r_inv_x       <= i_cfg_data[INV_BITS-1:0];
                REG_INV_Y:       r_inv_y       <= i_cfg_data[INV_BITS-1:0];
                REG_INV_Z:       r_inv_z       <= i_cfg_data[INV_BITS-1:0];
                REG_GRID_COUNTS: r_counts      <= i_cfg_data[GRID_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign cx = r_counts[0 +: COUNT_BITS];
    assign cy = r_counts[COUNT_BITS +: COUNT_BITS];
    assign cz = r_counts[2*COUNT_BITS +: COUNT_BITS];

    // Stage enables, from the output backwards.
    always_comb begin
        en6    = !r_out_valid || !i_out_stall;
        en5    = !r_v5 || en6;
        en4    = !r_v4 || en5;
        emit   = r_v3 && en4;
        q_last = !r_probe_valid || (r_k == LAST_CORNER);
        en.s3  = !r_v3 || (emit && q_last);
        en.s2  = !r_v2 || en.s3;
        en.s1  = !r_v1 || en.s2;
    end

    assign o_in_stall = !en.s1;

    pgtw_axis u_axis_x (
        .i_clk(i_clk), .i_en(en), .i_pos(i_pos_x), .i_origin(r_origin_x),
        .i_inv(r_inv_x), .i_count(cx),
        .o_lo(x_lo), .o_hi(x_hi), .o_w_lo(wx_lo), .o_w_hi(wx_hi)
    );

    pgtw_axis u_axis_y (
        .i_clk(i_clk), .i_en(en), .i_pos(i_pos_y), .i_origin(r_origin_y),
        .i_inv(r_inv_y), .i_count(cy),
        .o_lo(y_lo), .o_hi(y_hi), .o_w_lo(wy_lo), .o_w_hi(wy_hi)
    );

    pgtw_axis u_axis_z (
        .i_clk(i_clk), .i_en(en), .i_pos(i_pos_z), .i_origin(r_origin_z),
        .i_inv(r_inv_z), .i_count(cz),
        .o_lo(z_lo), .o_hi(z_hi), .o_w_lo(wz_lo), .o_w_hi(wz_hi)
    );

    // Corner selection; a failing query selects zeros, giving index and weight zero.
    always_comb begin
        if (r_probe_valid) begin
            sel_ix = r_k[0] ? x_hi : x_lo;
            sel_iy = r_k[1] ? y_hi : y_lo;
            sel_iz = r_k[2] ? z_hi : z_lo;
            sel_wx = r_k[0] ? wx_hi : wx_lo;
            sel_wy = r_k[1] ? wy_hi : wy_lo;
            sel_wz = r_k[2] ? wz_hi : wz_lo;
        end else begin
            sel_ix = '0;
            sel_iy = '0;
            sel_iz = '0;
            sel_wx = '0;
            sel_wy = '0;
            sel_wz = '0;
        end
        n_pxy  = PROD_W'(sel_wx) * PROD_W'(sel_wy);
        n_izxy = GRID_BITS'(sel_iz) * GRID_BITS'(r_cxy);
        n_iyx  = (2*COUNT_BITS)'(sel_iy) * (2*COUNT_BITS)'(cx);
        w1     = round_w(r_pxy);
        n_p2   = PROD_W'(w1) * PROD_W'(r_wz4);
        n_idx  = IDX_W'(r_izxy) + IDX_W'(r_iyx) + IDX_W'(r_ix4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_k         <= FIRST_CORNER;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en.s1) begin
                r_v1 <= i_in_valid;
            end
            if (en.s2) begin
                r_v2 <= r_v1;
            end
            if (en.s3) begin
                r_v3 <= r_v2;
            end
            if (emit) begin
                r_k <= q_last ? FIRST_CORNER : t_corner'(r_k + 1'b1);
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
            if (en6) begin
                r_out_valid <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s3) begin
            r_cxy <= (2*COUNT_BITS)'(cx) * (2*COUNT_BITS)'(cy);
        end
        if (en4) begin
            r_st4   <= r_probe_valid ? STATUS_OK : STATUS_NO_DATA;
            r_k4    <= r_k;
            r_last4 <= q_last;
            r_pxy   <= n_pxy;
            r_wz4   <= sel_wz;
            r_izxy  <= n_izxy;
            r_iyx   <= n_iyx;
            r_ix4   <= sel_ix;
        end
        if (en5) begin
            r_st5   <= r_st4;
            r_k5    <= r_k4;
            r_last5 <= r_last4;
            r_p2    <= n_p2;
            r_idx5  <= n_idx[INDEX_BITS-1:0];
        end
        if (en6) begin
            r_status <= r_st5;
            r_corner <= r_k5;
            r_last   <= r_last5;
            r_index  <= r_idx5;
            r_weight <= round_w(r_p2);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_lookup_status = r_status;
    assign o_corner        = r_corner;
    assign o_probe_index   = r_index;
    assign o_corner_weight = r_weight;
    assign o_last          = r_last;

endmodule

>>> rtl/pgtw_axis.sv
// One axis of the front pipeline: offset and clamp, scale by reciprocal spacing,
// then corner indices and side weights. Depends on pgtw_pkg.
module pgtw_axis (
    input  logic                                i_clk,
    input  pgtw_pkg::t_front_en                 i_en,
    input  logic signed [pgtw_pkg::POS_BITS-1:0] i_pos,
    input  logic signed [pgtw_pkg::POS_BITS-1:0] i_origin,
    input  logic [pgtw_pkg::INV_BITS-1:0]       i_inv,
    input  pgtw_pkg::t_count                    i_count,
    output pgtw_pkg::t_count                    o_lo,
    output pgtw_pkg::t_count                    o_hi,
    output pgtw_pkg::t_weight                   o_w_lo,
    output pgtw_pkg::t_weight                   o_w_hi
);
    import pgtw_pkg::*;

    logic signed [POS_BITS:0]           diff;
    logic [POS_BITS-1:0]                n_d;
    logic [POS_BITS-1:0]                r_d;
    logic [GCOORD_W-1:0]                prod;
    logic [GCOORD_W-1:0]                r_g;
    logic [FLOOR_W-1:0]                 fl;
    logic [GRID_FRAC-1:0]               frac;
    logic [GRID_FRAC+WEIGHT_BITS-1:0]   fwide;
    t_count                             maxi;
    t_count                             n_lo;
    t_count                             n_hi;
    t_weight                            n_w_hi;
    t_count                             r_lo;
    t_count                             r_hi;
    t_weight                            r_w_lo;
    t_weight                            r_w_hi;

    always_comb begin
        diff   = {i_pos[POS_BITS-1], i_pos} - {i_origin[POS_BITS-1], i_origin};
        n_d    = diff[POS_BITS] ? '0 : diff[POS_BITS-1:0];
        prod   = GCOORD_W'(r_d) * GCOORD_W'(i_inv);
        fl     = r_g[GCOORD_W-1:GRID_FRAC];
        frac   = r_g[GRID_FRAC-1:0];
        maxi   = (i_count == '0) ? '0 : t_count'(i_count - 1'b1);
        n_lo   = (fl > {{(FLOOR_W-COUNT_BITS){1'b0}}, maxi}) ? maxi : fl[COUNT_BITS-1:0];
        n_hi   = (n_lo == maxi) ? maxi : t_count'(n_lo + 1'b1);
        fwide  = {{WEIGHT_BITS{1'b0}}, frac} << FRAC_SHL;
        n_w_hi = t_weight'(fwide >> FRAC_SHR);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_d <= n_d;
        end
        if (i_en.s2) begin
            r_g <= prod;
        end
        if (i_en.s3) begin
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_w_hi <= n_w_hi;
            r_w_lo <= t_weight'(W_ONE - n_w_hi);
        end
    end

    assign o_lo   = r_lo;
    assign o_hi   = r_hi;
    assign o_w_lo = r_w_lo;
    assign o_w_hi = r_w_hi;

endmodule

>>> rtl/pgtw_checker.sv
// Port-level assertions for probe_grid_trilinear_weights and the bind that attaches them.
// Depends on pgtw_pkg.
module pgtw_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic                               o_lookup_status,
    input  logic [pgtw_pkg::CORNER_BITS-1:0]   o_corner,
    input  logic [pgtw_pkg::INDEX_BITS-1:0]    o_probe_index,
    input  logic [pgtw_pkg::WGT_W-1:0]         o_corner_weight,
    input  logic                               o_last
);
    import pgtw_pkg::*;

    a_fail_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_lookup_status == STATUS_NO_DATA) |->
            o_last && (o_corner == FIRST_CORNER) && (o_probe_index == '0)
            && (o_corner_weight == '0))
        else $error("failure word is not a single empty word");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_lookup_status == STATUS_OK) |->
            (o_last == (o_corner == LAST_CORNER)))
        else $error("last flag does not match the final corner");

    a_next_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=>
            o_out_valid && (o_corner == t_corner'($past(o_corner) + 1'b1)))
        else $error("corner words of one query are not consecutive");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_corner) && $stable(o_probe_index)
            && $stable(o_corner_weight) && $stable(o_last))
        else $error("stalled result word changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

endmodule

bind probe_grid_trilinear_weights pgtw_checker u_pgtw_checker (.*);
